[src/rnsd_pkg.sv]
// Ring node router package: packet and command types, codes and constants.
// No dependencies; imported by every module of the router, but not by rnsd_if.
package rnsd_pkg;

  localparam int WAIT_DEPTH_DEF = 16;
  localparam int MAX_NODES      = 256;
  localparam int CMDQ_DEPTH     = 2;
  localparam int CMDQ_AW        = $clog2(CMDQ_DEPTH);
  // remainder unit works one bit of a 9-bit dividend per cycle
  localparam int MOD_STEPS      = 9;
  localparam int MOD_CW         = $clog2(MOD_STEPS);

  localparam logic [7:0]  KIND_DISCOVERY = 8'd2;
  localparam logic [15:0] LFSR_SEED      = 16'hACE1;
  localparam logic [15:0] LFSR_MASK      = 16'hB400;

  typedef enum logic [1:0] {
    OP_LINK0 = 2'd0,
    OP_LINK1 = 2'd1,
    OP_APP   = 2'd2,
    OP_START = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PORT_LINK0 = 2'd0,
    PORT_LINK1 = 2'd1,
    PORT_APP   = 2'd2,
    PORT_DROP  = 2'd3
  } port_t;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_RING = 2'd1,
    CMD_APP  = 2'd2
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MOD,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [7:0]  kind;
    logic [7:0]  hop;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [31:0] tag;
  } packet_t;

  typedef struct packed {
    cmd_code_t code;
    port_t     port;
    packet_t   pkt;
  } cmd_t;

  typedef struct packed {
    port_t   port;
    packet_t pkt;
    logic    last;
  } result_t;

endpackage

[src/rnsd_if.sv]
// Valid/ready channel interfaces for the ring node router.
// Input word carries one packet or command; output word carries one sent packet.
interface rnsd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  kind;
  logic [7:0]  hop_count;
  logic [7:0]  source_node;
  logic [7:0]  destination;
  logic [31:0] packet_tag;

  modport source (output valid, op, kind, hop_count, source_node, destination, packet_tag,
                  input ready);
  modport sink   (input valid, op, kind, hop_count, source_node, destination, packet_tag,
                  output ready);
endinterface

interface rnsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_port;
  logic [7:0]  kind_res;
  logic [7:0]  hop_count_out;
  logic [7:0]  source_out;
  logic [7:0]  destination_out;
  logic [31:0] tag_out;
  logic        last;

  modport source (output valid, out_port, kind_res, hop_count_out, source_out,
                  destination_out, tag_out, last, input ready);
  modport sink   (input valid, out_port, kind_res, hop_count_out, source_out,
                  destination_out, tag_out, last, output ready);
endinterface

[src/ring_node_shortest_direction_router.sv]
// Top level of the ring node router: own-index register, front, queue, back.
// Depends on rnsd_pkg, rnsd_if, rnsd_front, rnsd_cmd_queue and rnsd_back.
//
//   channel    | dir | handshake          | word
//   -----------+-----+--------------------+-----------------------------------------
//   ingress    | in  | valid/ready        | op, kind, hop_count, source, dest., tag
//   egress     | out | valid/ready        | out_port, packet fields, last
//   cfg        | in  | cfg_we, no stall   | own_index (8 bits)
//
// The front takes one word a cycle while the two-entry command queue has room.
// The back handles a direct send, a ring update or a drop from the idle state; each
// packet drained from the wait store goes through read, load, nine remainder steps
// in the bit-serial unit and emit.
// Synchronous reset clears control state; the wait store is not cleared, its fill
// count guards reads. A stalled egress holds the result register and the back waits.
module ring_node_shortest_direction_router import rnsd_pkg::*; #(
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  rnsd_in_if.sink    ingress,
  rnsd_out_if.source egress
);

  logic [7:0] own_index;
  logic       push_valid;
  logic       push_ready;
  cmd_t       push_cmd;
  logic       pop_valid;
  logic       pop_ready;
  cmd_t       pop_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_index <= '0;
    end else if (cfg_we) begin
      own_index <= cfg_wdata;
    end
  end

  rnsd_front u_front (
    .ingress    (ingress),
    .own_index  (own_index),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  rnsd_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  rnsd_back #(
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .own_index (own_index),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .egress    (egress)
  );

  a_start_to_link0: assert property (@(posedge clk) disable iff (rst)
    ingress.valid && ingress.ready && ingress.op == OP_START |->
      push_cmd.code == CMD_SEND && push_cmd.port == PORT_LINK0 &&
      push_cmd.pkt.kind == KIND_DISCOVERY)
    else $error("start word not turned into a discovery send on link 0");

  a_drop_is_last: assert property (@(posedge clk) disable iff (rst)
    egress.valid && egress.out_port == PORT_DROP |-> egress.last)
    else $error("dropped word not marked last");

  a_app_is_mine: assert property (@(posedge clk) disable iff (rst)
    egress.valid && egress.out_port == PORT_APP |-> egress.destination_out == own_index)
    else $error("word for another node delivered to the app");

endmodule

[src/rnsd_front.sv]
// Front end: accepts input words and classifies them into back-end commands.
// Depends on rnsd_pkg and rnsd_in_if.
module rnsd_front import rnsd_pkg::*; (
  rnsd_in_if.sink    ingress,
  input  logic [7:0] own_index,
  output logic       push_valid,
  input  logic       push_ready,
  output cmd_t       push_cmd
);

  packet_t pkt_in;
  op_t     op;
  logic    for_me;
  logic    discovery;

  assign op        = op_t'(ingress.op);
  assign pkt_in    = '{kind: ingress.kind, hop: ingress.hop_count, src: ingress.source_node,
                       dst: ingress.destination, tag: ingress.packet_tag};
  assign for_me    = (ingress.destination == own_index);
  assign discovery = (ingress.kind == KIND_DISCOVERY);

  assign push_valid    = ingress.valid;
  assign ingress.ready = push_ready;

  always_comb begin
    push_cmd = '{code: CMD_APP, port: PORT_DROP, pkt: pkt_in};
    priority if (op == OP_START) begin
      push_cmd.code = CMD_SEND;
      push_cmd.port = PORT_LINK0;
      push_cmd.pkt  = '{kind: KIND_DISCOVERY, hop: 8'd0, src: own_index, dst: own_index,
                        tag: 32'd0};
    end else if (discovery && for_me) begin
      push_cmd.code = CMD_RING;
    end else if (for_me) begin
      push_cmd.code = CMD_SEND;
      push_cmd.port = PORT_APP;
    end else if (op == OP_LINK0 || op == OP_LINK1) begin
      // pass-through leaves by the opposite link
      push_cmd.code = CMD_SEND;
      push_cmd.port = (op == OP_LINK0) ? PORT_LINK1 : PORT_LINK0;
      if (discovery) begin
        push_cmd.pkt.hop = ingress.hop_count + 8'd1;
      end
    end else begin
      push_cmd.code = CMD_APP;
    end
  end

endmodule

[src/rnsd_cmd_queue.sv]
// Short command queue between the front and back ends of the router.
// Depends on rnsd_pkg.
module rnsd_cmd_queue import rnsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t                 slot [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr;
  logic [CMDQ_AW-1:0]   rd_ptr;
  logic [CMDQ_AW:0]     fill;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (fill != (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  // depth is a power of two, so pointers wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[src/rnsd_back.sv]
// Back end: runs commands, holds ring state, the wait store and the output register.
// Depends on rnsd_pkg and rnsd_out_if.
module rnsd_back import rnsd_pkg::*; #(
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] own_index,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  rnsd_out_if.source egress
);

  localparam int AW = $clog2(WAIT_DEPTH);
  localparam int CW = $clog2(WAIT_DEPTH + 1);
  localparam logic [8:0] RING_CAP = 9'(MAX_NODES);

  back_state_t state, state_next;

  logic [8:0]        ring_size, ring_size_next;
  logic              ring_known, ring_known_next;
  logic [AW-1:0]     head, head_next;
  logic [CW-1:0]     count, count_next;
  logic [15:0]       lfsr, lfsr_next;
  logic              pend, pend_next;

  packet_t           cur_pkt, cur_pkt_next;
  logic [8:0]        dividend, dividend_next;
  logic [8:0]        rem, rem_next;
  logic [MOD_CW-1:0] step, step_next;

  packet_t           mem [WAIT_DEPTH];
  packet_t           rd_pkt;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  packet_t           wr_pkt;

  logic              res_valid;
  result_t           res;
  logic              emit;
  result_t           emit_res;
  logic              slot_free;

  logic              full;
  logic [AW:0]       tail_sum;
  logic [AW-1:0]     tail;
  logic [AW-1:0]     head_inc;
  logic [8:0]        ring_n;
  logic [9:0]        dividend_init;
  logic [9:0]        rem_sh;
  logic [8:0]        rem_trial;
  logic [8:0]        other_way;
  logic              tie;
  port_t             pick;
  logic [15:0]       lfsr_adv;

  assign full      = (count == CW'(WAIT_DEPTH));
  assign tail_sum  = (AW+1)'(head) + (AW+1)'(count);
  assign tail      = (tail_sum >= (AW+1)'(WAIT_DEPTH)) ?
                     AW'(tail_sum - (AW+1)'(WAIT_DEPTH)) : AW'(tail_sum);
  assign head_inc  = (head == AW'(WAIT_DEPTH - 1)) ? '0 : head + 1'b1;
  assign slot_free = !res_valid || egress.ready;

  assign ring_n = ((9'({1'b0, cmd.pkt.hop}) + 9'd1) > RING_CAP) ? RING_CAP :
                  9'({1'b0, cmd.pkt.hop}) + 9'd1;

  // offset to the destination, kept positive before the remainder
  assign dividend_init = 10'({2'b00, rd_pkt.dst}) + 10'd256 - 10'({2'b00, own_index});

  // restoring remainder, one dividend bit a cycle
  assign rem_sh    = {rem, dividend[8]};
  assign rem_trial = (rem_sh >= {1'b0, ring_size}) ? 9'(rem_sh - {1'b0, ring_size}) :
                     rem_sh[8:0];

  assign other_way = ring_size - rem;
  assign tie       = (rem == other_way);
  assign lfsr_adv  = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_MASK : 16'h0000);

  always_comb begin
    if (rem > other_way) begin
      pick = PORT_LINK0;
    end else if (rem < other_way) begin
      pick = PORT_LINK1;
    end else begin
      pick = lfsr[0] ? PORT_LINK1 : PORT_LINK0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.code == CMD_APP && ring_known) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_MOD;
      ST_MOD: begin
        if (step == '0) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_next = (count == CW'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    emit            = 1'b0;
    emit_res        = '{port: PORT_DROP, pkt: cmd.pkt, last: 1'b1};
    cmd_ready       = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = tail;
    wr_pkt          = cmd.pkt;
    ring_size_next  = ring_size;
    ring_known_next = ring_known;
    head_next       = head;
    count_next      = count;
    lfsr_next       = lfsr;
    pend_next       = pend;
    cur_pkt_next    = cur_pkt;
    dividend_next   = dividend;
    rem_next        = rem;
    step_next       = step;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.code)
            CMD_SEND: begin
              if (slot_free) begin
                emit          = 1'b1;
                emit_res.port = cmd.port;
                cmd_ready     = 1'b1;
              end
            end
            CMD_RING: begin
              ring_size_next  = ring_n;
              ring_known_next = 1'b1;
              cmd_ready       = 1'b1;
            end
            CMD_APP: begin
              if (full) begin
                if (ring_known) begin
                  // drain first, the new word goes in afterwards
                  pend_next = 1'b1;
                end else if (slot_free) begin
                  emit      = 1'b1;
                  cmd_ready = 1'b1;
                end
              end else begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
                pend_next  = 1'b0;
                if (!ring_known) begin
                  cmd_ready = 1'b1;
                end
              end
            end
            default: cmd_ready = 1'b1;
          endcase
        end
      end
      ST_READ: begin
      end
      ST_LOAD: begin
        cur_pkt_next  = rd_pkt;
        dividend_next = dividend_init[8:0];
        rem_next      = '0;
        step_next     = MOD_CW'(MOD_STEPS - 1);
      end
      ST_MOD: begin
        dividend_next = {dividend[7:0], 1'b0};
        rem_next      = rem_trial;
        step_next     = step - 1'b1;
      end
      ST_EMIT: begin
        if (slot_free) begin
          emit          = 1'b1;
          emit_res.port = pick;
          emit_res.pkt  = cur_pkt;
          emit_res.last = (count == CW'(1));
          head_next     = head_inc;
          count_next    = count - 1'b1;
          if (tie) begin
            lfsr_next = lfsr_adv;
          end
          if (count == CW'(1)) begin
            cmd_ready = 1'b1;
            if (pend) begin
              wr_en      = 1'b1;
              wr_addr    = head_inc;
              count_next = CW'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_pkt;
    end
    rd_pkt <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ring_size  <= '0;
      ring_known <= 1'b0;
      head       <= '0;
      count      <= '0;
      lfsr       <= LFSR_SEED;
      pend       <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      ring_size  <= ring_size_next;
      ring_known <= ring_known_next;
      head       <= head_next;
      count      <= count_next;
      lfsr       <= lfsr_next;
      pend       <= pend_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (egress.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_pkt  <= cur_pkt_next;
    dividend <= dividend_next;
    rem      <= rem_next;
    step     <= step_next;
    if (emit) begin
      res <= emit_res;
    end
  end

  assign egress.valid           = res_valid;
  assign egress.out_port        = res.port;
  assign egress.kind_res        = res.pkt.kind;
  assign egress.hop_count_out   = res.pkt.hop;
  assign egress.source_out      = res.pkt.src;
  assign egress.destination_out = res.pkt.dst;
  assign egress.tag_out         = res.pkt.tag;
  assign egress.last            = res.last;

endmodule
